### rtl/wsla_pkg.sv
// ----------------------------------------------------------------------------
// wsla_pkg
// Types, codes and debounce constants shared by the link alarm debounce block.
// ----------------------------------------------------------------------------
package wsla_pkg;

  // Debounce lengths in ticks
  localparam int unsigned LEVEL_DEBOUNCE_TICKS = 3;   // 1 .. 15
  localparam int unsigned LINK_DEBOUNCE_TICKS  = 2;   // 1 .. 14

  // Counter widths: level counters hold LEVEL_DEBOUNCE_TICKS,
  // the no-link counter saturates at LINK_DEBOUNCE_TICKS + 1
  localparam int unsigned LvlCntW  = $clog2(LEVEL_DEBOUNCE_TICKS + 1);
  localparam int unsigned LinkCntW = $clog2(LINK_DEBOUNCE_TICKS + 2);

  localparam logic [LvlCntW-1:0]  LvlCntMax  = LvlCntW'(LEVEL_DEBOUNCE_TICKS);
  localparam logic [LinkCntW-1:0] LinkCntSat = LinkCntW'(LINK_DEBOUNCE_TICKS + 1);

  localparam int unsigned AddrW = 48;

  // Configuration register indexes
  localparam logic CFG_RSSI_THRESHOLD = 1'b0;
  localparam logic CFG_DUAL_SSID      = 1'b1;

  // Reset value of the RSSI threshold: -80 dBm
  localparam logic signed [7:0] RssiThresholdRst = -8'sd80;

  typedef enum logic [1:0] {
    NC_NONE   = 2'd0,
    NC_ENDED  = 2'd1,
    NC_ACTIVE = 2'd2
  } nc_report_e;

  typedef enum logic [1:0] {
    AP_EV_NONE       = 2'd0,
    AP_EV_CONNECT    = 2'd1,
    AP_EV_DISCONNECT = 2'd2
  } ap_event_e;

  typedef enum logic [1:0] {
    SSID_NONE      = 2'd0,
    SSID_PRIMARY   = 2'd1,
    SSID_SECONDARY = 2'd2
  } ssid_e;

  typedef struct packed {
    logic              mode;
    logic              reconfiguring;
    logic              associated;
    logic signed [7:0] rssi_dbm;
    logic [AddrW-1:0]  ap_address;
    logic [1:0]        ssid_match;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        not_connected_report;
    logic              low_level_report;
    logic              level_valid;
    logic signed [7:0] reported_level;
    logic [1:0]        ap_event;
    logic [AddrW-1:0]  ap_event_address;
    logic [1:0]        ssid_event;
  } out_item_t;

  typedef struct packed {
    logic       index;
    logic [7:0] data;
  } cfg_wr_t;

  // Register contents handed to the tracker
  typedef struct packed {
    logic signed [7:0] rssi_threshold;
    logic              dual_ssid_enable;
  } cfg_t;

endpackage

### rtl/wsla_intf.sv
// ----------------------------------------------------------------------------
// wsla_intf
// Valid/ready channels of the link alarm debounce block.
// ----------------------------------------------------------------------------
interface wsla_in_if;
  logic                valid;
  logic                ready;
  wsla_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wsla_out_if;
  logic                valid;
  logic                ready;
  wsla_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wsla_cfg_if;
  logic                valid;
  logic                ready;
  wsla_pkg::cfg_wr_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/wsla_cfg_regs.sv
// ----------------------------------------------------------------------------
// wsla_cfg_regs
// Configuration registers: RSSI threshold and dual SSID enable.
// ----------------------------------------------------------------------------
module wsla_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  input  wsla_pkg::cfg_wr_t   wr_i,
  output logic                wr_ready_o,
  output wsla_pkg::cfg_t      cfg_o
);

  logic signed [7:0] thr_q, thr_d;
  logic              dual_q, dual_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    thr_d  = thr_q;
    dual_d = dual_q;
    if (wr_valid_i) begin
      case (wr_i.index)
        wsla_pkg::CFG_RSSI_THRESHOLD: thr_d  = wr_i.data;
        wsla_pkg::CFG_DUAL_SSID:      dual_d = wr_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= wsla_pkg::RssiThresholdRst;
      dual_q <= 1'b0;
    end else begin
      thr_q  <= thr_d;
      dual_q <= dual_d;
    end
  end

  assign cfg_o.rssi_threshold   = thr_q;
  assign cfg_o.dual_ssid_enable = dual_q;

endmodule

### rtl/wsla_tracker.sv
// ----------------------------------------------------------------------------
// wsla_tracker
// Debounce counters, held alarms and access point / SSID memory; computes
// the result of one tick and commits the state update on en_i.
// ----------------------------------------------------------------------------
module wsla_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  wsla_pkg::cfg_t      cfg_i,
  input  wsla_pkg::in_item_t  item_i,
  output wsla_pkg::out_item_t res_o
);

  localparam int unsigned LvW = wsla_pkg::LvlCntW;
  localparam int unsigned LkW = wsla_pkg::LinkCntW;

  logic [LkW-1:0]             nolink_q, nolink_d;
  logic [LvW-1:0]             low_q, low_d, good_q, good_d;
  logic [1:0]                 ssid_q, ssid_d;
  logic                       apmem_q, apmem_d;
  logic [wsla_pkg::AddrW-1:0] addr_q, addr_d;
  logic                       low_held_q, low_held_d;
  logic                       nc_held_q, nc_held_d;

  logic [LkW:0] nolink_inc;
  logic [LvW:0] low_inc, good_inc, low_n, good_n;

  assign nolink_inc = {1'b0, nolink_q} + (LkW+1)'(1);
  assign low_inc    = {1'b0, low_q} + (LvW+1)'(1);
  assign good_inc   = {1'b0, good_q} + (LvW+1)'(1);

  always_comb begin
    nolink_d   = nolink_q;
    low_d      = low_q;
    good_d     = good_q;
    ssid_d     = ssid_q;
    apmem_d    = apmem_q;
    addr_d     = addr_q;
    low_held_d = low_held_q;
    nc_held_d  = nc_held_q;
    low_n      = '0;
    good_n     = '0;
    res_o      = '0;

    if (!item_i.mode && !item_i.reconfiguring) begin
      // link debounce
      if (!item_i.associated) begin
        if (nolink_inc >= (LkW+1)'(wsla_pkg::LINK_DEBOUNCE_TICKS)) begin
          nolink_d = wsla_pkg::LinkCntSat;
        end else begin
          nolink_d = nolink_inc[LkW-1:0];
        end
      end else begin
        nolink_d = '0;
      end

      if (!item_i.associated &&
          nolink_inc >= (LkW+1)'(wsla_pkg::LINK_DEBOUNCE_TICKS)) begin
        // link lost
        res_o.not_connected_report = wsla_pkg::NC_ACTIVE;
        res_o.low_level_report     = 1'b1;
        nc_held_d  = 1'b1;
        low_held_d = 1'b1;
        low_d      = wsla_pkg::LvlCntMax;
        good_d     = '0;
        ssid_d     = wsla_pkg::SSID_NONE;
        if (apmem_q) begin
          res_o.ap_event         = wsla_pkg::AP_EV_DISCONNECT;
          res_o.ap_event_address = addr_q;
          apmem_d = 1'b0;
          addr_d  = '0;
        end
      end else begin
        res_o.not_connected_report = wsla_pkg::NC_ENDED;
        nc_held_d = 1'b0;

        // access point tracking
        if (item_i.ap_address != '0) begin
          if (apmem_q) begin
            if (addr_q != item_i.ap_address) begin
              res_o.ap_event         = wsla_pkg::AP_EV_DISCONNECT;
              res_o.ap_event_address = addr_q;
              apmem_d = 1'b0;
              addr_d  = '0;
            end
          end else begin
            res_o.ap_event         = wsla_pkg::AP_EV_CONNECT;
            res_o.ap_event_address = item_i.ap_address;
            apmem_d = 1'b1;
            addr_d  = item_i.ap_address;
          end
        end

        // level debounce
        if (item_i.rssi_dbm < cfg_i.rssi_threshold) begin
          low_n  = low_inc;
          good_n = '0;
        end else begin
          low_n  = '0;
          good_n = good_inc;
        end
        if (low_n >= (LvW+1)'(wsla_pkg::LEVEL_DEBOUNCE_TICKS)) begin
          low_d  = wsla_pkg::LvlCntMax;
          good_d = good_n[LvW-1:0];
          res_o.low_level_report = 1'b1;
        end else if (good_n >= (LvW+1)'(wsla_pkg::LEVEL_DEBOUNCE_TICKS)) begin
          low_d  = low_n[LvW-1:0];
          good_d = wsla_pkg::LvlCntMax;
          res_o.low_level_report = 1'b0;
        end else begin
          low_d  = low_n[LvW-1:0];
          good_d = good_n[LvW-1:0];
          res_o.low_level_report = low_held_q;
        end
        low_held_d           = res_o.low_level_report;
        res_o.level_valid    = 1'b1;
        res_o.reported_level = item_i.rssi_dbm;

        // SSID switching; codes other than primary/secondary change nothing
        if (cfg_i.dual_ssid_enable) begin
          if (item_i.ssid_match == wsla_pkg::SSID_PRIMARY &&
              ssid_q != wsla_pkg::SSID_PRIMARY) begin
            res_o.ssid_event = wsla_pkg::SSID_PRIMARY;
            ssid_d           = wsla_pkg::SSID_PRIMARY;
          end else if (item_i.ssid_match == wsla_pkg::SSID_SECONDARY &&
                       ssid_q != wsla_pkg::SSID_SECONDARY) begin
            res_o.ssid_event = wsla_pkg::SSID_SECONDARY;
            ssid_d           = wsla_pkg::SSID_SECONDARY;
          end
        end else begin
          ssid_d = wsla_pkg::SSID_NONE;
        end
      end
    end else if (!item_i.mode) begin
      // reconfiguring: report held alarms, touch nothing
      res_o.low_level_report     = low_held_q;
      res_o.level_valid          = 1'b1;
      res_o.reported_level       = item_i.rssi_dbm;
      res_o.not_connected_report = nc_held_q ? wsla_pkg::NC_ACTIVE : wsla_pkg::NC_ENDED;
    end else begin
      // access point or monitor mode
      low_d      = '0;
      good_d     = '0;
      low_held_d = 1'b0;
      ssid_d     = wsla_pkg::SSID_PRIMARY;
      nolink_d   = '0;
      if (apmem_q) begin
        res_o.ap_event         = wsla_pkg::AP_EV_DISCONNECT;
        res_o.ap_event_address = addr_q;
      end
      apmem_d = 1'b0;
      addr_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nolink_q   <= '0;
      low_q      <= '0;
      good_q     <= '0;
      ssid_q     <= wsla_pkg::SSID_PRIMARY;
      apmem_q    <= 1'b0;
      addr_q     <= '0;
      low_held_q <= 1'b0;
      nc_held_q  <= 1'b0;
    end else if (en_i) begin
      nolink_q   <= nolink_d;
      low_q      <= low_d;
      good_q     <= good_d;
      ssid_q     <= ssid_d;
      apmem_q    <= apmem_d;
      addr_q     <= addr_d;
      low_held_q <= low_held_d;
      nc_held_q  <= nc_held_d;
    end
  end

endmodule

### rtl/wireless_station_link_alarm_debounce.sv
// ----------------------------------------------------------------------------
// wireless_station_link_alarm_debounce
// Per-tick debounce of the not-connected and low-RSSI alarms with access
// point connect/disconnect and SSID switch events.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload              | transaction
//  --------+-----+----------------------+------------------------------------
//  in_i    | in  | wsla_pkg::in_item_t  | one tick of radio status
//  out_o   | out | wsla_pkg::out_item_t | one result per tick, in order
//  cfg_i   | in  | wsla_pkg::cfg_wr_t   | register write (index, data)
//
//  Flow: a tick is registered, evaluated combinationally by the tracker and
//  its result lands in the output register; one tick per cycle sustained
//  while out_o is ready. The tracker's state update sets that rate.
//  Reset: rst_ni async active low clears both stage valids, the tracker
//  state and the config registers (threshold -80 dBm, dual SSID off).
//  Stalls: a waiting result holds the output register; the input register
//  still takes a tick while the output register drains in the same cycle.
//  Config writes are always ready and apply on the next cycle.
//
module wireless_station_link_alarm_debounce (
  input  logic clk_i,
  input  logic rst_ni,
  wsla_in_if.sink    in_i,
  wsla_out_if.source out_o,
  wsla_cfg_if.sink   cfg_i
);

  // input stage
  logic                in_valid_q, in_valid_d;
  wsla_pkg::in_item_t  in_data_q;
  // result stage
  logic                out_valid_q, out_valid_d;
  wsla_pkg::out_item_t out_data_q;

  wsla_pkg::cfg_t      cfg;
  wsla_pkg::out_item_t res;
  logic                advance;   // tick moves from input to result stage
  logic                in_take;

  wsla_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_i       (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  // state commits exactly once per tick, when the tick moves forward
  wsla_tracker u_trk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .cfg_i  (cfg),
    .item_i (in_data_q),
    .res_o  (res)
  );

  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_i.data;
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // a tick that moves forward shows up as a result next cycle
  a_advance_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced tick did not reach the result register");

  // a tick stuck in the input stage is neither lost nor overwritten
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q))
    else $error("held input tick was lost or changed");

  // a not-connected result carries the low-level alarm or a valid level
  a_nc_forces_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.not_connected_report == wsla_pkg::NC_ACTIVE &&
    !in_data_q.reconfiguring |-> out_data_q.low_level_report ||
    out_data_q.level_valid)
    else $error("not-connected result without low-level alarm");

  // no level is attached when level_valid is low
  a_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.level_valid |-> out_data_q.reported_level == 8'sd0)
    else $error("reported_level nonzero while not valid");

  // a connect event always names a known access point
  a_connect_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.ap_event == wsla_pkg::AP_EV_CONNECT |->
    out_data_q.ap_event_address != '0)
    else $error("connect event with unknown address");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the station link alarm debounce. A scoreboard
// mirrors the debounce counters, held alarms, access point memory and SSID
// tracking, predicts one report per accepted tick and checks every output
// transaction field by field, in order, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import wsla_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  wsla_in_if  in_if ();
  wsla_out_if out_if ();
  wsla_cfg_if cfg_if ();

  wireless_station_link_alarm_debounce u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  in_item_t  pending_ticks[$];     // ticks waiting for the driver
  out_item_t expected_reports[$];  // predicted reports, oldest first

  bit in_taken;            // tick transaction at the last rising edge
  bit gaps_on = 1'b1;      // random idle cycles on both channels
  int hold_req = 0;        // long sink hold-offs requested by the stimulus
  int hold_served = 0;
  int hold_left = 0;
  int errors = 0;
  int report_idx = 0;

  out_item_t exp_rep;
  out_item_t got_rep;

  // Scoreboard copy of the registers and tracker state (reset values)
  logic signed [7:0]   thr_setting  = RssiThresholdRst;
  logic                dual_setting = 1'b0;
  logic [LinkCntW-1:0] no_link_cnt  = '0;
  logic [LvlCntW-1:0]  low_cnt      = '0;
  logic [LvlCntW-1:0]  good_cnt     = '0;
  ssid_e               cur_ssid     = SSID_PRIMARY;
  logic                ap_known     = 1'b0;
  logic [AddrW-1:0]    ap_held      = '0;
  logic                low_held     = 1'b0;
  logic                nc_held      = 1'b0;

  // --------------------------------------------------------------------------
  // Tracker prediction: one report per tick, updates the scoreboard state
  // --------------------------------------------------------------------------
  function automatic out_item_t debounce_tick(input in_item_t t);
    out_item_t r;
    logic      link_up;
    r = '0;
    if (!t.mode && !t.reconfiguring) begin
      // Active station: no-link counter saturates one past the debounce
      link_up = 1'b1;
      if (!t.associated) begin
        if (no_link_cnt != LinkCntSat) no_link_cnt = no_link_cnt + 1'b1;
        if (no_link_cnt >= LINK_DEBOUNCE_TICKS) begin
          link_up     = 1'b0;
          no_link_cnt = LinkCntSat;
        end
      end else begin
        no_link_cnt = '0;
      end

      if (!link_up) begin
        // Link lost: both alarms active, level unknown, forget the AP
        r.not_connected_report = NC_ACTIVE;
        nc_held                = 1'b1;
        r.low_level_report     = 1'b1;
        low_held               = 1'b1;
        low_cnt                = LvlCntMax;
        good_cnt               = '0;
        cur_ssid               = SSID_NONE;
        if (ap_known) begin
          r.ap_event         = AP_EV_DISCONNECT;
          r.ap_event_address = ap_held;
          ap_known           = 1'b0;
          ap_held            = '0;
        end
      end else begin
        r.not_connected_report = NC_ENDED;
        nc_held                = 1'b0;

        // Address 0 is unknown; a new address first drops the old AP and
        // is only reported connected on a later tick
        if (t.ap_address != '0) begin
          if (ap_known) begin
            if (ap_held != t.ap_address) begin
              r.ap_event         = AP_EV_DISCONNECT;
              r.ap_event_address = ap_held;
              ap_known           = 1'b0;
              ap_held            = '0;
            end
          end else begin
            ap_known           = 1'b1;
            ap_held            = t.ap_address;
            r.ap_event         = AP_EV_CONNECT;
            r.ap_event_address = t.ap_address;
          end
        end

        // Separate set/clear counters, held state in between
        if ($signed(t.rssi_dbm) < thr_setting) begin
          if (low_cnt < LvlCntMax) low_cnt = low_cnt + 1'b1;
          good_cnt = '0;
        end else begin
          low_cnt = '0;
          if (good_cnt < LvlCntMax) good_cnt = good_cnt + 1'b1;
        end
        if (low_cnt >= LvlCntMax) r.low_level_report = 1'b1;
        else if (good_cnt >= LvlCntMax) r.low_level_report = 1'b0;
        else r.low_level_report = low_held;
        low_held         = r.low_level_report;
        r.level_valid    = 1'b1;
        r.reported_level = t.rssi_dbm;

        if (dual_setting) begin
          // Codes 0 and 3 match neither SSID and leave it alone
          if (t.ssid_match == SSID_PRIMARY && cur_ssid != SSID_PRIMARY) begin
            r.ssid_event = SSID_PRIMARY;
            cur_ssid     = SSID_PRIMARY;
          end else if (t.ssid_match == SSID_SECONDARY && cur_ssid != SSID_SECONDARY) begin
            r.ssid_event = SSID_SECONDARY;
            cur_ssid     = SSID_SECONDARY;
          end
        end else begin
          cur_ssid = SSID_NONE;
        end
      end
    end else if (!t.mode) begin
      // Reconfiguring station: report held alarms, touch nothing
      r.low_level_report     = low_held;
      r.level_valid          = 1'b1;
      r.reported_level       = t.rssi_dbm;
      r.not_connected_report = nc_held ? NC_ACTIVE : NC_ENDED;
    end else begin
      // AP / monitor mode: level alarm ends, not-connected left as held
      low_cnt     = '0;
      good_cnt    = '0;
      low_held    = 1'b0;
      cur_ssid    = SSID_PRIMARY;
      no_link_cnt = '0;
      if (ap_known) begin
        r.ap_event         = AP_EV_DISCONNECT;
        r.ap_event_address = ap_held;
      end
      ap_known = 1'b0;
      ap_held  = '0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: checks output transactions, then predicts for the tick and
  // register write accepted at the same edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got_rep = out_if.data;
        if (expected_reports.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t report %0d: nothing expected, got nc=%0d low=%0d vld=%0d lvl=%0d ap=%0d addr=%h ssid=%0d",
                     $realtime, report_idx, got_rep.not_connected_report,
                     got_rep.low_level_report, got_rep.level_valid,
                     $signed(got_rep.reported_level), got_rep.ap_event,
                     got_rep.ap_event_address, got_rep.ssid_event);
        end else begin
          exp_rep = expected_reports.pop_front();
          if (got_rep.not_connected_report !== exp_rep.not_connected_report ||
              got_rep.low_level_report     !== exp_rep.low_level_report     ||
              got_rep.level_valid          !== exp_rep.level_valid          ||
              got_rep.reported_level       !== exp_rep.reported_level       ||
              got_rep.ap_event             !== exp_rep.ap_event             ||
              got_rep.ap_event_address     !== exp_rep.ap_event_address     ||
              got_rep.ssid_event           !== exp_rep.ssid_event) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t report %0d exp: nc=%0d low=%0d vld=%0d lvl=%0d ap=%0d addr=%h ssid=%0d",
                       $realtime, report_idx, exp_rep.not_connected_report,
                       exp_rep.low_level_report, exp_rep.level_valid,
                       $signed(exp_rep.reported_level), exp_rep.ap_event,
                       exp_rep.ap_event_address, exp_rep.ssid_event);
              $display("%0t report %0d got: nc=%0d low=%0d vld=%0d lvl=%0d ap=%0d addr=%h ssid=%0d",
                       $realtime, report_idx, got_rep.not_connected_report,
                       got_rep.low_level_report, got_rep.level_valid,
                       $signed(got_rep.reported_level), got_rep.ap_event,
                       got_rep.ap_event_address, got_rep.ssid_event);
            end
          end
        end
        report_idx++;
      end

      if (in_if.valid && in_if.ready) begin
        in_taken = 1'b1;
        expected_reports.push_back(debounce_tick(in_if.data));
      end

      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.data.index == CFG_RSSI_THRESHOLD) thr_setting = $signed(cfg_if.data.data);
        else if (cfg_if.data.index == CFG_DUAL_SSID) dual_setting = cfg_if.data.data[0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tick driver: a tick stays on the bus until its transaction completes
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (pending_ticks.size() != 0 && !(gaps_on && $urandom_range(99) < 6)) begin
        in_if.data  <= pending_ticks.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Report sink: random stalls, plus a long hold-off on request so the
  // pipeline fills up and backpressures the tick channel
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left    = hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_served != hold_req) begin
      hold_served  = hold_served + 1;
      hold_left    = 250;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !(gaps_on && $urandom_range(99) < 6);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [AddrW-1:0] random_ap_address();
    return {16'($urandom), $urandom};
  endfunction

  task automatic add_tick(input logic m, input logic rc, input logic as, input int lvl,
                          input logic [AddrW-1:0] addr, input logic [1:0] match);
    in_item_t t;
    if (lvl > 127) lvl = 127;
    else if (lvl < -128) lvl = -128;
    t.mode          = m;
    t.reconfiguring = rc;
    t.associated    = as;
    t.rssi_dbm      = lvl[7:0];
    t.ap_address    = addr;
    t.ssid_match    = match;
    pending_ticks.push_back(t);
  endtask

  // Register writes only while nothing is in flight
  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_if.data  <= '{index: idx, data: val};
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Sender pause: everything driven and every report back, then latency
  task automatic drain();
    while (pending_ticks.size() != 0 || in_if.valid || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly well-formed station traffic around the threshold with a sticky
  // AP, plus link drop bursts, reconfiguration, AP mode and pure noise
  task automatic queue_random_ticks(input int n, input logic signed [7:0] thr);
    int               cnt;
    int               kind;
    int               len;
    int               lvl;
    logic [AddrW-1:0] ap;
    cnt = 0;
    ap  = random_ap_address();
    while (cnt < n) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        if ($urandom_range(19) == 0) ap = ($urandom_range(3) == 0) ? '0 : random_ap_address();
        lvl = int'(thr) + int'($urandom_range(16)) - 8;
        if ($urandom_range(9) == 0) lvl = int'($urandom_range(255)) - 128;
        add_tick(1'b0, 1'b0, $urandom_range(19) != 0, lvl, ap, 2'($urandom_range(3)));
        cnt++;
      end else if (kind < 80) begin
        len = $urandom_range(1, 4);
        repeat (len)
          add_tick(1'b0, 1'b0, 1'b0, int'($urandom_range(255)) - 128, ap,
                   2'($urandom_range(3)));
        cnt += len;
      end else if (kind < 87) begin
        add_tick(1'b0, 1'b1, 1'($urandom), int'($urandom_range(255)) - 128, ap,
                 2'($urandom_range(3)));
        cnt++;
      end else if (kind < 93) begin
        add_tick(1'b1, 1'($urandom), 1'($urandom), int'($urandom_range(255)) - 128, ap,
                 2'($urandom_range(3)));
        cnt++;
      end else begin
        add_tick(1'($urandom), 1'($urandom), 1'($urandom), int'($urandom_range(255)) - 128,
                 ($urandom_range(3) == 0) ? '0 : random_ap_address(), 2'($urandom));
        cnt++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  localparam logic [AddrW-1:0] AP_LOW  = 48'h0000_0000_0001;
  localparam logic [AddrW-1:0] AP_HIGH = 48'hFFFF_FFFF_FFFF;

  initial begin
    logic signed [7:0] thr_list [8];
    logic              dual_list[8];
    int                ph;

    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed, reset registers (-80 dBm, dual SSID off)
    add_tick(1'b0, 1'b0, 1'b1,  127, AP_LOW, 2'd1);   // connect
    add_tick(1'b0, 1'b0, 1'b1, -128, AP_LOW, 2'd2);   // low count starts
    add_tick(1'b0, 1'b0, 1'b1,  -81, AP_LOW, 2'd0);
    add_tick(1'b0, 1'b0, 1'b1,  -80, AP_LOW, 2'd3);   // at threshold: good
    repeat (3) add_tick(1'b0, 1'b0, 1'b1, -128, AP_LOW, 2'd0);  // alarm set
    add_tick(1'b0, 1'b0, 1'b1,  127, AP_HIGH, 2'd0);  // AP change: drop old
    add_tick(1'b0, 1'b0, 1'b1,  127, AP_HIGH, 2'd0);  // then connect new
    add_tick(1'b0, 1'b0, 1'b1,    0, '0, 2'd0);       // unknown address
    add_tick(1'b0, 1'b1, 1'b0,   -1, '0, 2'd0);       // reconfiguring
    repeat (3) add_tick(1'b0, 1'b0, 1'b0, 5, AP_HIGH, 2'd0);  // link lost, saturate
    add_tick(1'b0, 1'b1, 1'b1,   -5, '0, 2'd1);       // reconfig, alarm held
    add_tick(1'b1, 1'b1, 1'b1,   10, AP_LOW, 2'd2);   // AP mode
    add_tick(1'b0, 1'b0, 1'b1,  127, AP_LOW, 2'd0);
    add_tick(1'b1, 1'b0, 1'b0, -128, AP_LOW, 2'd0);   // AP mode drops AP
    drain();

    // Directed, dual SSID on; upper data bits set on purpose
    write_reg(CFG_DUAL_SSID, 8'hFF);
    add_tick(1'b0, 1'b0, 1'b1, 127, '0, 2'd2);        // to secondary
    add_tick(1'b0, 1'b0, 1'b1, 127, '0, 2'd1);        // back to primary
    add_tick(1'b0, 1'b0, 1'b1, 127, '0, 2'd3);
    add_tick(1'b0, 1'b0, 1'b1, 127, '0, 2'd0);
    add_tick(1'b0, 1'b0, 1'b1, 127, '0, 2'd1);        // same SSID, no event
    repeat (2) add_tick(1'b0, 1'b0, 1'b0, 0, '0, 2'd2);  // link lost clears SSID
    add_tick(1'b0, 1'b0, 1'b1, 127, '0, 2'd1);
    drain();

    // Random phases across register settings, extremes included
    thr_list  = '{-8'sd80, -8'sd128, 8'sd127, 8'sd0, -8'sd60, 8'($urandom),
                  8'($urandom), -8'sd1};
    dual_list = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'($urandom), 1'b1, 1'b0};
    for (ph = 0; ph < 8; ph++) begin
      write_reg(CFG_RSSI_THRESHOLD, thr_list[ph]);
      write_reg(CFG_DUAL_SSID, {7'($urandom), dual_list[ph]});
      gaps_on = (ph != 4);   // one phase runs back to back on both sides
      queue_random_ticks(222, thr_list[ph]);
      if (ph == 2) hold_req++;
      drain();
    end
    gaps_on = 1'b1;

    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
rtl/wsla_pkg.sv
rtl/wsla_intf.sv
rtl/wsla_cfg_regs.sv
rtl/wsla_tracker.sv
rtl/wireless_station_link_alarm_debounce.sv
sim/tb_top.sv
